// ===== hw/rtl/multi_button_debouncer_assert.svh =====
// Assertion macros used by the checker file of the button debouncer.
`ifndef MULTI_BUTTON_DEBOUNCER_ASSERT_SVH
`define MULTI_BUTTON_DEBOUNCER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MBD_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("debouncer assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define MBD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("debouncer assertion failed");

`endif

// ===== hw/rtl/mbd_pkg.sv =====
// Package with the shared constants and types of the button debouncer.
package mbd_pkg;

	localparam int NUM_BUTTONS_DEF = 4;
	localparam int DELAY_WIDTH_DEF = 16;

	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_PRESS_DELAY   = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_DELAY = CFG_INDEX_W'(1);

	localparam logic [CFG_DATA_W-1:0] PRESS_DELAY_RST   = CFG_DATA_W'(20);
	localparam logic [CFG_DATA_W-1:0] RELEASE_DELAY_RST = CFG_DATA_W'(100);

	typedef struct packed {
		logic down_next;
		logic confirm;
	} btn_status_t;

endpackage

// ===== hw/rtl/mbd_item_if.sv =====
// Input channel of the button debouncer: one beat carries a tick, the pins and a read.
interface mbd_item_if #(
	parameter int NUM_BUTTONS = mbd_pkg::NUM_BUTTONS_DEF
);
	logic                   valid;
	logic                   ready;
	logic                   tick;
	logic [NUM_BUTTONS-1:0] pins;
	logic                   read_strobe;

	modport source (output valid, output tick, output pins, output read_strobe, input ready);
	modport sink (input valid, input tick, input pins, input read_strobe, output ready);
endinterface

// ===== hw/rtl/mbd_result_if.sv =====
// Result channel of the button debouncer: one beat per accepted input beat.
interface mbd_result_if #(
	parameter int NUM_BUTTONS = mbd_pkg::NUM_BUTTONS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [NUM_BUTTONS-1:0] read_data;
	logic                   read_ready;
	logic                   event_flag;
	logic [NUM_BUTTONS-1:0] pressed_mask;

	modport source (output valid, output read_data, output read_ready, output event_flag,
		output pressed_mask, input ready);
	modport sink (input valid, input read_data, input read_ready, input event_flag,
		input pressed_mask, output ready);
endinterface

// ===== hw/rtl/mbd_cfg_if.sv =====
// Configuration write channel of the button debouncer.
interface mbd_cfg_if;
	import mbd_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/mbd_button.sv =====
// State machine and tick countdown of one debounced button.
module mbd_button #(
	parameter int DELAY_WIDTH = mbd_pkg::DELAY_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic                   tick,
	input  logic                   level,
	input  logic                   prev_level,
	input  logic [DELAY_WIDTH-1:0] press_load,
	input  logic [DELAY_WIDTH-1:0] release_load,
	output mbd_pkg::btn_status_t   status
);
	import mbd_pkg::*;

	typedef enum logic [1:0] {
		BTN_UP,
		BTN_DOWN,
		BTN_UNCERTAIN
	} btn_state_t;

	btn_state_t             state_q;
	btn_state_t             state_d;
	logic [DELAY_WIDTH-1:0] count_q;
	logic [DELAY_WIDTH-1:0] count_d;
	logic [DELAY_WIDTH-1:0] count_dec;
	logic                   confirm;

	assign count_dec = count_q - DELAY_WIDTH'(1);

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		confirm = 1'b0;
		if (tick && (count_q != '0)) begin
			count_d = count_dec;
			if (count_dec == '0) begin
				if (!level) begin
					if (state_q == BTN_UNCERTAIN) begin
						state_d = BTN_DOWN;
						confirm = 1'b1;
					end
					count_d = release_load;
				end else begin
					state_d = BTN_UP;
				end
			end
		end
		if (prev_level && !level && (state_d == BTN_UP)) begin
			state_d = BTN_UNCERTAIN;
			count_d = press_load;
		end
	end

	assign status.down_next = (state_d == BTN_DOWN);
	assign status.confirm   = confirm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BTN_UP;
			count_q <= '0;
		end else if (step) begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end
endmodule

// ===== hw/rtl/multi_button_debouncer.sv =====
// Top level of the multi-button debouncer with its input and result registers.
// An accepted input beat goes to the input register, then the result register.
// Throughput is one beat per cycle, one pass of the button logic, unless stalled.
// Reset puts every button up with its countdown disarmed and clears the pending event.
// Reset also sets the previous pins to released and the delays to 20 and 100 ticks.
module multi_button_debouncer #(
	parameter int NUM_BUTTONS = mbd_pkg::NUM_BUTTONS_DEF,
	parameter int DELAY_WIDTH = mbd_pkg::DELAY_WIDTH_DEF
) (
	input logic         clk,
	input logic         arst_n,
	mbd_item_if.sink    item,
	mbd_result_if.source result,
	mbd_cfg_if.sink     cfg
);
	import mbd_pkg::*;

	function automatic logic [DELAY_WIDTH-1:0] load_value(input logic [CFG_DATA_W-1:0] d);
		logic [DELAY_WIDTH-1:0] v;
		if (d == '0) begin
			v = DELAY_WIDTH'(1);
		end else if ((d >> DELAY_WIDTH) != '0) begin
			v = '1;
		end else begin
			v = DELAY_WIDTH'(d);
		end
		return v;
	endfunction

	logic [DELAY_WIDTH-1:0] press_load_q;
	logic [DELAY_WIDTH-1:0] release_load_q;

	logic                   valid_s1;
	logic                   tick_s1;
	logic [NUM_BUTTONS-1:0] pins_s1;
	logic                   strobe_s1;

	logic [NUM_BUTTONS-1:0] prev_pins_q;
	logic                   event_q;

	logic                   out_valid_q;
	logic [NUM_BUTTONS-1:0] read_data_q;
	logic                   read_ready_q;
	logic                   event_flag_q;
	logic [NUM_BUTTONS-1:0] mask_q;

	logic                   advance;
	btn_status_t            status [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] mask_next;
	logic [NUM_BUTTONS-1:0] confirms;
	logic                   event_raised;
	logic                   read_hit;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_load_q   <= load_value(PRESS_DELAY_RST);
			release_load_q <= load_value(RELEASE_DELAY_RST);
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_PRESS_DELAY:   press_load_q   <= load_value(cfg.data);
				REG_RELEASE_DELAY: release_load_q <= load_value(cfg.data);
				default: ;
			endcase
		end
	end

	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			tick_s1   <= item.tick;
			pins_s1   <= item.pins;
			strobe_s1 <= item.read_strobe;
		end
	end

	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
		mbd_button #(
			.DELAY_WIDTH(DELAY_WIDTH)
		) u_button (
			.clk         (clk),
			.arst_n      (arst_n),
			.step        (advance),
			.tick        (tick_s1),
			.level       (pins_s1[i]),
			.prev_level  (prev_pins_q[i]),
			.press_load  (press_load_q),
			.release_load(release_load_q),
			.status      (status[i])
		);
		assign mask_next[i] = status[i].down_next;
		assign confirms[i]  = status[i].confirm;
	end

	assign event_raised = event_q || (|confirms);
	assign read_hit     = strobe_s1 && event_raised;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pins_q <= '1;
			event_q     <= 1'b0;
		end else if (advance) begin
			prev_pins_q <= pins_s1;
			event_q     <= event_raised && !read_hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_q  <= read_hit ? mask_next : '0;
			read_ready_q <= read_hit;
			event_flag_q <= event_raised && !read_hit;
			mask_q       <= mask_next;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.read_data    = read_data_q;
	assign result.read_ready   = read_ready_q;
	assign result.event_flag   = event_flag_q;
	assign result.pressed_mask = mask_q;
endmodule

// ===== hw/rtl/mbd_checker.sv =====
// Port-level checker of the button debouncer and its bind to the top level.
module mbd_checker #(
	parameter int NUM_BUTTONS = mbd_pkg::NUM_BUTTONS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [NUM_BUTTONS-1:0] read_data,
	input logic                   read_ready,
	input logic                   event_flag,
	input logic [NUM_BUTTONS-1:0] pressed_mask
);
	import mbd_pkg::*;

`include "multi_button_debouncer_assert.svh"

	// A successful read always consumes the pending event.
	`MBD_ASSERT_SAME(a_read_clears_event, out_valid && read_ready, !event_flag)
	// A failed or absent read returns an empty mask.
	`MBD_ASSERT_SAME(a_no_read_zero_data, out_valid && !read_ready, read_data == '0)
	// A successful read returns the debounced mask of the same beat.
	`MBD_ASSERT_SAME(a_read_data_is_mask, out_valid && read_ready, read_data == pressed_mask)
	// A stalled result beat holds its payload.
	`MBD_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready,
		out_valid && $stable(read_data) && $stable(pressed_mask) && $stable(event_flag))
endmodule

bind multi_button_debouncer mbd_checker #(
	.NUM_BUTTONS(NUM_BUTTONS)
) u_mbd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.read_data   (result.read_data),
	.read_ready  (result.read_ready),
	.event_flag  (result.event_flag),
	.pressed_mask(result.pressed_mask)
);
